[hw/rtl/trpr_pkg.sv]
// Shared types and constants for the touch report parser.
// Used by trpr_rotate and touch_report_parse_rotate_core; depends on nothing.
package trpr_pkg;

    localparam int unsigned MAX_POINTS = 5;

    localparam logic [7:0] READY_BIT  = 8'h80;
    localparam logic [3:0] COUNT_MASK = 4'h0f;

    // Byte positions within one 8-byte touch record.
    localparam logic [2:0] POS_ID    = 3'd0;
    localparam logic [2:0] POS_X_LO  = 3'd1;
    localparam logic [2:0] POS_X_HI  = 3'd2;
    localparam logic [2:0] POS_Y_LO  = 3'd3;
    localparam logic [2:0] POS_Y_HI  = 3'd4;
    localparam logic [2:0] POS_P_LO  = 3'd5;
    localparam logic [2:0] POS_P_HI  = 3'd6;
    localparam logic [2:0] POS_RSVD  = 3'd7;

    // Configuration register indexes.
    localparam logic [1:0] REG_ROTATION = 2'd0;
    localparam logic [1:0] REG_WIDTH    = 2'd1;
    localparam logic [1:0] REG_HEIGHT   = 2'd2;

    // Quarter-turn codes.
    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    localparam logic [15:0] PANEL_RESET = 16'd480;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] pressure;
        logic [3:0]  index;
        logic        touched;
        logic        last;
    } t_result;

endpackage

[hw/rtl/touch_report_parse_rotate_core.sv]
// Touch report parser top level: byte-serial record parsing and a skid-buffered
// result register. Depends on trpr_pkg and trpr_rotate.
//
// Usage:
//   Report bytes enter on the input channel (i_in_valid / o_in_stall), one byte per
//   request, with i_frame_start marking the status byte. Results leave on the output
//   channel (o_out_valid / i_out_stall): one no-touch result for an empty or not-ready
//   status byte, and one point on the pressure high byte of each record.
//   A result is registered in the output register when its byte is accepted, or in
//   the skid entry if that register holds a stalled result. Throughput: one byte per
//   cycle while o_in_stall is low; parsing and rotation are one logic pass before them.
//   The output side has a result register plus one skid entry, so a byte is still
//   taken while a finished result waits. o_in_stall rises only when both hold results,
//   which needs the receiver to stall across two result-producing bytes.
//   Configuration (rotation, panel width, panel height) is written through
//   i_cfg_we / i_cfg_index / i_cfg_data while the block is idle; writes to an unused
//   index are ignored.
//   Reset (synchronous, active low) empties the result stages, clears the parser state
//   and loads rotation 0 and a 480 by 480 panel.
module touch_report_parse_rotate_core
    import trpr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_report_byte,
    input  logic        i_frame_start,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_touch_x,
    output logic [15:0] o_touch_y,
    output logic [15:0] o_touch_pressure,
    output logic [3:0]  o_point_index,
    output logic        o_touched,
    output logic        o_last
);

    localparam logic [3:0] MAX_PTS = 4'(MAX_POINTS);

    logic [1:0]  r_rotation;
    logic [15:0] r_panel_width;
    logic [15:0] r_panel_height;

    logic [2:0]  r_byte_pos,  n_byte_pos;
    logic [3:0]  r_point_cnt, n_point_cnt;
    logic [3:0]  r_points_exp, n_points_exp;
    logic [15:0] r_x_hold,    n_x_hold;
    logic [15:0] r_y_hold,    n_y_hold;
    logic [7:0]  r_p_lo_hold, n_p_lo_hold;

    logic        r_out_valid;
    t_result     r_out;
    logic        r_skid_valid;
    t_result     r_skid;

    logic        in_accept;
    logic        out_take;
    logic        produce;
    t_result     new_res;
    logic [3:0]  status_cnt;
    logic [3:0]  cnt_inc;
    logic [15:0] rot_x;
    logic [15:0] rot_y;

    assign o_in_stall = r_skid_valid;
    assign in_accept  = i_in_valid && !r_skid_valid;
    assign out_take   = r_out_valid && !i_out_stall;

    trpr_rotate u_rotate (
        .i_rotation     (r_rotation),
        .i_panel_width  (r_panel_width),
        .i_panel_height (r_panel_height),
        .i_raw_x        (r_x_hold),
        .i_raw_y        (r_y_hold),
        .o_x            (rot_x),
        .o_y            (rot_y)
    );

    always_comb begin
        n_byte_pos   = r_byte_pos;
        n_point_cnt  = r_point_cnt;
        n_points_exp = r_points_exp;
        n_x_hold     = r_x_hold;
        n_y_hold     = r_y_hold;
        n_p_lo_hold  = r_p_lo_hold;
        produce      = 1'b0;
        status_cnt   = i_report_byte[3:0] & COUNT_MASK;
        cnt_inc      = r_point_cnt + 4'd1;
        new_res      = '0;
        new_res.last = 1'b1;

        if (in_accept) begin
            if (i_frame_start) begin
                n_byte_pos  = POS_ID;
                n_point_cnt = 4'd0;
                if (((i_report_byte & READY_BIT) == 8'd0) || (status_cnt == 4'd0)) begin
                    // Not ready or empty: a single no-touch result closes the report.
                    n_points_exp = 4'd0;
                    produce      = 1'b1;
                end else begin
                    n_points_exp = (status_cnt > MAX_PTS) ? MAX_PTS : status_cnt;
                end
            end else if (r_point_cnt < r_points_exp) begin
                n_byte_pos = r_byte_pos + 3'd1;
                case (r_byte_pos)
                    POS_X_LO: n_x_hold    = {8'd0, i_report_byte};
                    POS_X_HI: n_x_hold    = {i_report_byte, r_x_hold[7:0]};
                    POS_Y_LO: n_y_hold    = {8'd0, i_report_byte};
                    POS_Y_HI: n_y_hold    = {i_report_byte, r_y_hold[7:0]};
                    POS_P_LO: n_p_lo_hold = i_report_byte;
                    POS_P_HI: begin
                        n_point_cnt      = cnt_inc;
                        produce          = 1'b1;
                        new_res.x        = rot_x;
                        new_res.y        = rot_y;
                        new_res.pressure = {i_report_byte, r_p_lo_hold};
                        new_res.index    = r_point_cnt;
                        new_res.touched  = 1'b1;
                        new_res.last     = (cnt_inc >= r_points_exp);
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rotation     <= ROT_0;
            r_panel_width  <= PANEL_RESET;
            r_panel_height <= PANEL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ROTATION: r_rotation     <= i_cfg_data[1:0];
                REG_WIDTH:    r_panel_width  <= i_cfg_data;
                REG_HEIGHT:   r_panel_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_pos   <= '0;
            r_point_cnt  <= '0;
            r_points_exp <= '0;
            r_x_hold     <= '0;
            r_y_hold     <= '0;
            r_p_lo_hold  <= '0;
        end else begin
            r_byte_pos   <= n_byte_pos;
            r_point_cnt  <= n_point_cnt;
            r_points_exp <= n_points_exp;
            r_x_hold     <= n_x_hold;
            r_y_hold     <= n_y_hold;
            r_p_lo_hold  <= n_p_lo_hold;
        end
    end

    // A new result goes to the output register when it is free, else to the skid
    // entry. Bytes are refused while the skid entry is full, so the two never collide.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_take || !r_out_valid) begin
            r_out_valid  <= r_skid_valid || produce;
            r_skid_valid <= 1'b0;
        end else if (produce) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take || !r_out_valid) begin
            r_out <= r_skid_valid ? r_skid : new_res;
        end else if (produce) begin
            r_skid <= new_res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_touch_x        = r_out.x;
    assign o_touch_y        = r_out.y;
    assign o_touch_pressure = r_out.pressure;
    assign o_point_index    = r_out.index;
    assign o_touched        = r_out.touched;
    assign o_last           = r_out.last;

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry holds a result while the output register is empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_point_cnt <= r_points_exp) && (r_points_exp <= MAX_PTS))
        else $error("point counter or expected count out of range");

    a_no_touch_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.touched) |->
            (r_out.last && (r_out.x == 16'd0) && (r_out.y == 16'd0) &&
             (r_out.pressure == 16'd0) && (r_out.index == 4'd0)))
        else $error("no-touch result carries point data");

    a_start_resets_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_frame_start) |=> ((r_byte_pos == POS_ID) && (r_point_cnt == 4'd0)))
        else $error("status byte did not restart record parsing");

    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall && produce) |=> o_in_stall)
        else $error("stalled result with a new one did not raise the input stall");

endmodule

[hw/rtl/trpr_rotate.sv]
// Coordinate rotation for the touch report parser: orientation swap, quarter turn
// and clamp at zero. Purely combinational; depends on trpr_pkg.
module trpr_rotate
    import trpr_pkg::*;
(
    input  logic [1:0]  i_rotation,
    input  logic [15:0] i_panel_width,
    input  logic [15:0] i_panel_height,
    input  logic [15:0] i_raw_x,
    input  logic [15:0] i_raw_y,
    output logic [15:0] o_x,
    output logic [15:0] o_y
);

    logic        landscape;
    logic [15:0] dim_lo;
    logic [15:0] dim_hi;
    logic [15:0] eff_w;
    logic [15:0] eff_h;
    logic [17:0] w_minus_x;
    logic [17:0] w_minus_y;
    logic [17:0] h_minus_x;
    logic [17:0] h_minus_y;

    // Clamp a signed 18-bit difference at zero and keep 16 bits.
    function automatic logic [15:0] clamp0(input logic [17:0] v);
        clamp0 = v[17] ? 16'd0 : v[15:0];
    endfunction

    always_comb begin
        landscape = (i_rotation == ROT_90) || (i_rotation == ROT_270);
        dim_lo    = (i_panel_width < i_panel_height) ? i_panel_width : i_panel_height;
        dim_hi    = (i_panel_width < i_panel_height) ? i_panel_height : i_panel_width;
        eff_w     = landscape ? dim_hi : dim_lo;
        eff_h     = landscape ? dim_lo : dim_hi;

        w_minus_x = {2'b00, eff_w} - 18'd1 - {2'b00, i_raw_x};
        w_minus_y = {2'b00, eff_w} - 18'd1 - {2'b00, i_raw_y};
        h_minus_x = {2'b00, eff_h} - 18'd1 - {2'b00, i_raw_x};
        h_minus_y = {2'b00, eff_h} - 18'd1 - {2'b00, i_raw_y};

        unique case (i_rotation)
            ROT_90: begin
                o_x = i_raw_y;
                o_y = clamp0(h_minus_x);
            end
            ROT_180: begin
                o_x = clamp0(w_minus_x);
                o_y = clamp0(h_minus_y);
            end
            ROT_270: begin
                o_x = clamp0(w_minus_y);
                o_y = i_raw_x;
            end
            default: begin
                o_x = i_raw_x;
                o_y = i_raw_y;
            end
        endcase
    end

endmodule
